// ----- design/jsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_BODY    = 4'd1,
      MODE_ESC     = 4'd2,
      MODE_HEX     = 4'd3,
      MODE_LOW_BS  = 4'd4,
      MODE_LOW_U   = 4'd5,
      MODE_LOW_HEX = 4'd6
   } mode_type;

   // all results caused by one input transaction
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      ndata;
      logic            tail_en;
      logic [1:0]      tail_kind;
   } packet_type;

endpackage

// ----- design/jsu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// Decodes one input byte per cycle while take is high into its result packet.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          in_byte,
   input  logic                start_req,
   input  logic                final_byte,
   output logic                pkt_valid,
   output jsu_pkg::packet_type pkt
);

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_B = 8'h62;
   localparam logic [7:0] CHAR_F = 8'h66;
   localparam logic [7:0] CHAR_N = 8'h6E;
   localparam logic [7:0] CHAR_R = 8'h72;
   localparam logic [7:0] CHAR_T = 8'h74;
   localparam logic [7:0] CHAR_U = 8'h75;
   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0] LOW_SURR_TAG = 6'b110111;
   localparam logic [20:0] CP_MAX_1 = 21'h7F;
   localparam logic [20:0] CP_MAX_2 = 21'h7FF;
   localparam logic [20:0] CP_MAX_3 = 21'hFFFF;
   localparam logic [20:0] CP_MAX_4 = 21'h10FFFF;
   localparam logic [20:0] CP_PLANE_1 = 21'h10000;

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [15:0] hex_acc_ff, hex_acc_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;
   logic [9:0]  high_ff, high_in;

   logic        nib_ok;
   logic [3:0]  nib;
   logic [15:0] acc_next;
   logic        err;
   logic        done_q;
   logic        put_one;
   logic [7:0]  one_byte;
   logic        put_cp;
   logic [20:0] cp;

   always_comb begin
      nib_ok = 1'b1;
      nib    = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         nib = in_byte[3:0];
      end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                   (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
         nib = in_byte[3:0] + 4'd9;
      end else begin
         nib_ok = 1'b0;
      end
   end

   assign acc_next = {hex_acc_ff[11:0], nib};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= jsu_pkg::MODE_IDLE;
         hex_acc_ff <= '0;
         hex_cnt_ff <= '0;
         high_ff    <= '0;
      end else if (take) begin
         mode_ff    <= mode_in;
         hex_acc_ff <= hex_acc_in;
         hex_cnt_ff <= hex_cnt_in;
         high_ff    <= high_in;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      hex_acc_in = hex_acc_ff;
      hex_cnt_in = hex_cnt_ff;
      high_in    = high_ff;
      err        = 1'b0;
      done_q     = 1'b0;
      put_one    = 1'b0;
      one_byte   = in_byte;
      put_cp     = 1'b0;
      cp         = '0;
      if (start_req) begin
         hex_acc_in = '0;
         hex_cnt_in = '0;
         high_in    = '0;
         if (in_byte == CHAR_QUOTE) begin
            mode_in = jsu_pkg::MODE_BODY;
         end else begin
            err = 1'b1;
         end
      end else begin
         case (mode_ff)
            jsu_pkg::MODE_BODY: begin
               if (in_byte == CHAR_QUOTE) begin
                  done_q  = 1'b1;
                  mode_in = jsu_pkg::MODE_IDLE;
               end else if (in_byte == CHAR_BSLASH) begin
                  mode_in = jsu_pkg::MODE_ESC;
               end else begin
                  put_one = 1'b1;
               end
            end
            jsu_pkg::MODE_ESC: begin
               mode_in = jsu_pkg::MODE_BODY;
               case (in_byte)
                  CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: put_one = 1'b1;
                  CHAR_B: begin
                     put_one  = 1'b1;
                     one_byte = 8'h08;
                  end
                  CHAR_F: begin
                     put_one  = 1'b1;
                     one_byte = 8'h0C;
                  end
                  CHAR_N: begin
                     put_one  = 1'b1;
                     one_byte = 8'h0A;
                  end
                  CHAR_R: begin
                     put_one  = 1'b1;
                     one_byte = 8'h0D;
                  end
                  CHAR_T: begin
                     put_one  = 1'b1;
                     one_byte = 8'h09;
                  end
                  CHAR_U: begin
                     hex_acc_in = '0;
                     hex_cnt_in = '0;
                     mode_in    = jsu_pkg::MODE_HEX;
                  end
                  default: err = 1'b1;
               endcase
            end
            jsu_pkg::MODE_HEX: begin
               if (!nib_ok) begin
                  err = 1'b1;
               end else begin
                  hex_acc_in = acc_next;
                  if (hex_cnt_ff == 2'd3) begin
                     hex_cnt_in = '0;
                     if (acc_next[15:10] == HIGH_SURR_TAG) begin
                        high_in = acc_next[9:0];
                        mode_in = jsu_pkg::MODE_LOW_BS;
                     end else if (acc_next[15:10] == LOW_SURR_TAG) begin
                        err = 1'b1;
                     end else begin
                        cp      = {5'd0, acc_next};
                        put_cp  = 1'b1;
                        mode_in = jsu_pkg::MODE_BODY;
                     end
                  end else begin
                     hex_cnt_in = hex_cnt_ff + 2'd1;
                  end
               end
            end
            jsu_pkg::MODE_LOW_BS: begin
               if (in_byte == CHAR_BSLASH) begin
                  mode_in = jsu_pkg::MODE_LOW_U;
               end else begin
                  err = 1'b1;
               end
            end
            jsu_pkg::MODE_LOW_U: begin
               if (in_byte == CHAR_U) begin
                  hex_acc_in = '0;
                  hex_cnt_in = '0;
                  mode_in    = jsu_pkg::MODE_LOW_HEX;
               end else begin
                  err = 1'b1;
               end
            end
            jsu_pkg::MODE_LOW_HEX: begin
               if (!nib_ok) begin
                  err = 1'b1;
               end else begin
                  hex_acc_in = acc_next;
                  if (hex_cnt_ff == 2'd3) begin
                     hex_cnt_in = '0;
                     if (acc_next[15:10] != LOW_SURR_TAG) begin
                        err = 1'b1;
                     end else begin
                        cp      = CP_PLANE_1 + {1'b0, high_ff, acc_next[9:0]};
                        put_cp  = 1'b1;
                        mode_in = jsu_pkg::MODE_BODY;
                     end
                  end else begin
                     hex_cnt_in = hex_cnt_ff + 2'd1;
                  end
               end
            end
            default: mode_in = jsu_pkg::MODE_IDLE;
         endcase
      end
      if (err) begin
         mode_in = jsu_pkg::MODE_IDLE;
      end
      if (final_byte && mode_in != jsu_pkg::MODE_IDLE) begin
         err     = 1'b1;
         mode_in = jsu_pkg::MODE_IDLE;
      end
   end

   always_comb begin
      pkt = '0;
      if (put_one) begin
         pkt.data[0] = one_byte;
         pkt.ndata   = 3'd1;
      end else if (put_cp) begin
         if (cp <= CP_MAX_1) begin
            pkt.data[0] = cp[7:0];
            pkt.ndata   = 3'd1;
         end else if (cp <= CP_MAX_2) begin
            pkt.data[0] = {3'b110, cp[10:6]};
            pkt.data[1] = {2'b10, cp[5:0]};
            pkt.ndata   = 3'd2;
         end else if (cp <= CP_MAX_3) begin
            pkt.data[0] = {4'b1110, cp[15:12]};
            pkt.data[1] = {2'b10, cp[11:6]};
            pkt.data[2] = {2'b10, cp[5:0]};
            pkt.ndata   = 3'd3;
         end else if (cp <= CP_MAX_4) begin
            pkt.data[0] = {5'b11110, cp[20:18]};
            pkt.data[1] = {2'b10, cp[17:12]};
            pkt.data[2] = {2'b10, cp[11:6]};
            pkt.data[3] = {2'b10, cp[5:0]};
            pkt.ndata   = 3'd4;
         end
      end
      if (done_q) begin
         pkt.tail_en   = 1'b1;
         pkt.tail_kind = jsu_pkg::KIND_DONE;
      end else if (err) begin
         pkt.tail_en   = 1'b1;
         pkt.tail_kind = jsu_pkg::KIND_ERROR;
      end
   end

   assign pkt_valid = (pkt.ndata != 3'd0) || pkt.tail_en;

endmodule

// ----- design/jsu_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_queue
// Short packet queue between the decoder and the result serialiser.
// ----------------------------------------------------------------------------
module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jsu_pkg::packet_type push_pkt,
   output logic                full,
   input  logic                pop,
   output jsu_pkg::packet_type pop_pkt,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_pkg::packet_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_pkt = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_pkt;
      end
   end

endmodule

// ----- design/jsu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// Unpacks queued packets into single results held in an output register.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  jsu_pkg::packet_type q_pkt,
   output logic                q_pop,
   input  logic                pop,
   output logic                empty,
   output logic [7:0]          out_byte,
   output logic [1:0]          out_kind,
   output logic                last
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] kind_ff, kind_in;
   logic       last_ff, last_in;
   logic [2:0] total;
   logic       load, emit, is_last;

   assign total   = q_pkt.ndata + {2'd0, q_pkt.tail_en};
   assign load    = !valid_ff || pop;
   assign emit    = load && !q_empty;
   assign is_last = (idx_ff == total - 3'd1);
   assign q_pop   = emit && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !pop;
      byte_in  = byte_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         last_in  = is_last;
         idx_in   = is_last ? 3'd0 : idx_ff + 3'd1;
         if (idx_ff < q_pkt.ndata) begin
            byte_in = q_pkt.data[idx_ff[1:0]];
            kind_in = jsu_pkg::KIND_DATA;
         end else begin
            byte_in = '0;
            kind_in = q_pkt.tail_kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign empty    = !valid_ff;
   assign out_byte = byte_ff;
   assign out_kind = kind_ff;
   assign last     = last_ff;

endmodule

// ----- design/json_string_unescape_utf8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming JSON string literal decoder producing UTF-8 bytes and a status.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   push / full      req_in_byte, req_start_req, req_final_byte
//  response  pop / empty      rsp_out_byte, rsp_out_kind, rsp_last
//
//  one input byte is taken per cycle while the packet queue has room
//  results leave the output register one per cycle while pop is high, so a
//  byte that causes n results (n up to 5) holds the serialiser for all n
//  first result goes through the packet queue, then the output register
//  synchronous reset empties the queue and closes any open string
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_start_req,
   input  logic       req_final_byte,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_out_kind,
   output logic       rsp_last
);

   jsu_pkg::packet_type front_pkt, head_pkt;
   logic front_valid, take, q_empty, q_pop;

   assign take = push && !full;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .in_byte    (req_in_byte),
      .start_req  (req_start_req),
      .final_byte (req_final_byte),
      .pkt_valid  (front_valid),
      .pkt        (front_pkt)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (take && front_valid),
      .push_pkt (front_pkt),
      .full     (full),
      .pop      (q_pop),
      .pop_pkt  (head_pkt),
      .empty    (q_empty)
   );

   jsu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pkt    (head_pkt),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .out_byte (rsp_out_byte),
      .out_kind (rsp_out_kind),
      .last     (rsp_last)
   );

endmodule
